[rtl/mwss_pkg.sv]
// ----------------------------------------------------------------------------
// Mecanum wheel setpoint shaper package
// Shared payload types, register and mode codes, and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package mwss_pkg;

  typedef enum logic [1:0] {
    TargetOff    = 2'd0,
    TargetNormal = 2'd1,
    TargetStatic = 2'd2,
    TargetSpare  = 2'd3
  } mwss_target_e;

  typedef enum logic {
    InputSticks = 1'b0,
    InputKeys   = 1'b1
  } mwss_input_e;

  typedef enum logic [2:0] {
    RegRcCenter      = 3'd0,
    RegRcDeadband    = 3'd1,
    RegRcGain        = 3'd2,
    RegKeySpeed      = 3'd3,
    RegKeyTurnSpeed  = 3'd4,
    RegWheelLimit    = 3'd5,
    RegBoostGap      = 3'd6,
    RegBoostMinSpeed = 3'd7
  } mwss_reg_e;

  localparam int unsigned AddrWidth = 5;

  // Q16 factors.
  localparam logic signed [17:0] QBoostFactor = 18'sd1311;
  localparam logic signed [17:0] QAwayFactor  = -18'sd65470;
  localparam logic signed [17:0] QBrakeFactor = -18'sd58982;
  localparam logic [14:0]        QSlowFactor  = 15'd28836;

  localparam logic signed [19:0] CmdMax = 20'sd524287;
  localparam logic signed [19:0] CmdMin = -20'sd524288;

  typedef struct packed {
    logic [1:0]  target;
    logic        input_mode;
    logic [10:0] stick_x;
    logic [10:0] stick_y;
    logic [10:0] stick_turn;
    logic        key_forward;
    logic        key_back;
    logic        key_left;
    logic        key_right;
    logic        key_slow;
    logic        mouse_left;
    logic        mouse_right;
  } mwss_in_t;

  typedef struct packed {
    logic signed [15:0] wheel_a;
    logic signed [15:0] wheel_b;
    logic signed [15:0] wheel_c;
    logic signed [15:0] wheel_d;
    logic               power_off;
  } mwss_out_t;

  typedef struct packed {
    logic        ramp_mode;
    logic        boost_en;
    logic [14:0] boost_gap;
    logic [14:0] boost_min_speed;
  } mwss_shape_ctrl_t;

endpackage

`default_nettype wire

[rtl/mwss_cmd_shaper.sv]
// ----------------------------------------------------------------------------
// Command shaper
// Updates one stored command from its raw speed: boost in normal mode, slow
// ramp and fast brake in static mode, saturated to the command range.
// ----------------------------------------------------------------------------
`default_nettype none

module mwss_cmd_shaper (
  input  logic signed [19:0]         raw_i,
  input  logic signed [19:0]         cmd_i,
  input  mwss_pkg::mwss_shape_ctrl_t ctrl_i,
  output logic signed [19:0]         cmd_o
);

  logic signed [20:0] diff;
  logic        [20:0] diff_abs;
  logic signed [19:0] min_speed;
  logic               boost_hit;
  logic               away;
  logic               use_mult;
  logic signed [17:0] factor;
  logic signed [38:0] prod;
  logic signed [38:0] sum;
  logic signed [38:0] sum_adj;
  logic signed [22:0] quot;
  logic signed [19:0] quot_sat;

  assign diff      = $signed({raw_i[19], raw_i}) - $signed({cmd_i[19], cmd_i});
  assign diff_abs  = diff[20] ? 21'(-diff) : 21'(diff);
  assign min_speed = $signed({5'b0, ctrl_i.boost_min_speed});
  assign boost_hit = (diff_abs > {6'b0, ctrl_i.boost_gap}) &&
                     ((raw_i > min_speed) || (raw_i < -min_speed));
  assign away      = ((raw_i > 20'sd0) && (raw_i > cmd_i)) ||
                     ((raw_i < 20'sd0) && (raw_i < cmd_i));

  always_comb begin
    if (ctrl_i.ramp_mode) begin
      factor = away ? mwss_pkg::QAwayFactor : mwss_pkg::QBrakeFactor;
    end else begin
      factor = mwss_pkg::QBoostFactor;
    end
  end

  assign prod    = 39'(factor) * 39'(diff);
  assign sum     = $signed({{3{raw_i[19]}}, raw_i, 16'h0000}) + prod;
  // Division by 65536 rounds toward zero.
  assign sum_adj = sum[38] ? sum + 39'sd65535 : sum;
  assign quot    = $signed(sum_adj[38:16]);

  always_comb begin
    if (quot > 23'(mwss_pkg::CmdMax)) begin
      quot_sat = mwss_pkg::CmdMax;
    end else if (quot < 23'(mwss_pkg::CmdMin)) begin
      quot_sat = mwss_pkg::CmdMin;
    end else begin
      quot_sat = quot[19:0];
    end
  end

  assign use_mult = ctrl_i.ramp_mode || (ctrl_i.boost_en && boost_hit);
  assign cmd_o    = use_mult ? quot_sat : raw_i;

endmodule

`default_nettype wire

[rtl/mecanum_wheel_setpoint_shaper_unit.sv]
// ----------------------------------------------------------------------------
// Mecanum wheel setpoint shaper
// Forms chassis speeds from sticks or keys, shapes them into stored commands
// and mixes them into four saturated mecanum wheel setpoints.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while the output side is not
// stalled and returns one result per transaction, in order. A transaction
// passes the raw speed register, the command register (where the stored side,
// forward and turn commands are updated, one multiplier per command) and the
// output register that holds the mixed and saturated wheel setpoints.
// Power-off transactions give zero setpoints with the power-off flag and leave
// the stored commands untouched.
`default_nettype none

module mecanum_wheel_setpoint_shaper_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  mwss_pkg::mwss_in_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output mwss_pkg::mwss_out_t               out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mwss_pkg::AddrWidth-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  function automatic logic signed [19:0] stick_raw(input logic [10:0] ch,
                                                   input logic [10:0] center,
                                                   input logic [9:0]  deadband,
                                                   input logic [7:0]  gain);
    logic        [12:0] hi;
    logic signed [12:0] lo;
    logic signed [11:0] offset;
    logic signed [20:0] prod;
    hi     = {2'b0, center} + {3'b0, deadband};
    lo     = $signed({2'b0, center}) - $signed({3'b0, deadband});
    offset = $signed({1'b0, center}) - $signed({1'b0, ch});
    prod   = 21'(offset) * 21'($signed({1'b0, gain}));
    if (({2'b0, ch} > hi) || ($signed({2'b0, ch}) < lo)) begin
      return prod[19:0];
    end
    return 20'sd0;
  endfunction

  function automatic logic signed [19:0] key_raw(input logic        plus,
                                                 input logic        minus,
                                                 input logic [14:0] speed,
                                                 input logic        slow);
    logic [29:0] scaled;
    logic [14:0] mag;
    scaled = 30'(speed) * 30'(mwss_pkg::QSlowFactor);
    mag    = slow ? {1'b0, scaled[29:16]} : speed;
    if (plus && !minus) begin
      return $signed({5'b0, mag});
    end else if (minus && !plus) begin
      return -$signed({5'b0, mag});
    end
    return 20'sd0;
  endfunction

  function automatic logic signed [15:0] sat_wheel(input logic signed [21:0] v,
                                                   input logic [14:0]        lim);
    logic signed [21:0] lim_s;
    lim_s = $signed({7'b0, lim});
    if (v > lim_s) begin
      return lim_s[15:0];
    end else if (v < -lim_s) begin
      return 16'(-lim_s);
    end
    return v[15:0];
  endfunction

  // Configuration registers.
  logic [10:0] rc_center_q;
  logic [9:0]  rc_deadband_q;
  logic [7:0]  rc_gain_q;
  logic [14:0] key_speed_q;
  logic [14:0] key_turn_speed_q;
  logic [14:0] wheel_limit_q;
  logic [14:0] boost_gap_q;
  logic [14:0] boost_min_speed_q;

  logic                cfg_write;
  mwss_pkg::mwss_reg_e cfg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_sel   = mwss_pkg::mwss_reg_e'(paddr[mwss_pkg::AddrWidth-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_center_q       <= 11'd1024;
      rc_deadband_q     <= 10'd20;
      rc_gain_q         <= 8'd10;
      key_speed_q       <= 15'd2500;
      key_turn_speed_q  <= 15'd1500;
      wheel_limit_q     <= 15'd10000;
      boost_gap_q       <= 15'd100;
      boost_min_speed_q <= 15'd1000;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        mwss_pkg::RegRcCenter:      rc_center_q       <= pwdata[10:0];
        mwss_pkg::RegRcDeadband:    rc_deadband_q     <= pwdata[9:0];
        mwss_pkg::RegRcGain:        rc_gain_q         <= pwdata[7:0];
        mwss_pkg::RegKeySpeed:      key_speed_q       <= pwdata[14:0];
        mwss_pkg::RegKeyTurnSpeed:  key_turn_speed_q  <= pwdata[14:0];
        mwss_pkg::RegWheelLimit:    wheel_limit_q     <= pwdata[14:0];
        mwss_pkg::RegBoostGap:      boost_gap_q       <= pwdata[14:0];
        mwss_pkg::RegBoostMinSpeed: boost_min_speed_q <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      mwss_pkg::RegRcCenter:      prdata = {21'b0, rc_center_q};
      mwss_pkg::RegRcDeadband:    prdata = {22'b0, rc_deadband_q};
      mwss_pkg::RegRcGain:        prdata = {24'b0, rc_gain_q};
      mwss_pkg::RegKeySpeed:      prdata = {17'b0, key_speed_q};
      mwss_pkg::RegKeyTurnSpeed:  prdata = {17'b0, key_turn_speed_q};
      mwss_pkg::RegWheelLimit:    prdata = {17'b0, wheel_limit_q};
      mwss_pkg::RegBoostGap:      prdata = {17'b0, boost_gap_q};
      mwss_pkg::RegBoostMinSpeed: prdata = {17'b0, boost_min_speed_q};
      default:                    prdata = 32'b0;
    endcase
  end

  // Pipeline flow control.
  logic raw_valid_q, cmd_valid_q, out_valid_q;
  logic out_en, cmd_en, raw_en;

  assign out_en     = !out_valid_q || out_ready_i;
  assign cmd_en     = !cmd_valid_q || out_en;
  assign raw_en     = !raw_valid_q || cmd_en;
  assign in_ready_o = raw_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_valid_q <= 1'b0;
      cmd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (raw_en) begin
        raw_valid_q <= in_valid_i;
      end
      if (cmd_en) begin
        cmd_valid_q <= raw_valid_q;
      end
      if (out_en) begin
        out_valid_q <= cmd_valid_q;
      end
    end
  end

  // Raw speed stage.
  logic signed [19:0] raw_side_d, raw_fwd_d, raw_turn_d;
  logic signed [19:0] raw_side_q, raw_fwd_q, raw_turn_q;
  logic               raw_off_d, raw_static_d;
  logic               raw_off_q, raw_static_q;
  logic               raw_load;

  always_comb begin
    if (mwss_pkg::mwss_input_e'(in_data_i.input_mode) == mwss_pkg::InputSticks) begin
      raw_side_d = stick_raw(in_data_i.stick_x, rc_center_q, rc_deadband_q, rc_gain_q);
      raw_fwd_d  = stick_raw(in_data_i.stick_y, rc_center_q, rc_deadband_q, rc_gain_q);
      raw_turn_d = stick_raw(in_data_i.stick_turn, rc_center_q, rc_deadband_q, rc_gain_q);
    end else begin
      raw_side_d = key_raw(in_data_i.key_left, in_data_i.key_right, key_speed_q,
                           in_data_i.key_slow);
      raw_fwd_d  = key_raw(in_data_i.key_back, in_data_i.key_forward, key_speed_q,
                           in_data_i.key_slow);
      raw_turn_d = key_raw(in_data_i.mouse_left, in_data_i.mouse_right,
                           key_turn_speed_q, in_data_i.key_slow);
    end
  end

  assign raw_static_d = (mwss_pkg::mwss_target_e'(in_data_i.target) == mwss_pkg::TargetStatic);
  assign raw_off_d    = !raw_static_d &&
                        (mwss_pkg::mwss_target_e'(in_data_i.target) != mwss_pkg::TargetNormal);
  assign raw_load     = in_valid_i && raw_en;

  always_ff @(posedge clk_i) begin
    if (raw_load) begin
      raw_side_q   <= raw_side_d;
      raw_fwd_q    <= raw_fwd_d;
      raw_turn_q   <= raw_turn_d;
      raw_off_q    <= raw_off_d;
      raw_static_q <= raw_static_d;
    end
  end

  // Command stage.
  logic signed [19:0]         side_cmd_q, fwd_cmd_q, turn_cmd_q;
  logic signed [19:0]         side_cmd_d, fwd_cmd_d, turn_cmd_d;
  logic                       cmd_off_q;
  logic                       cmd_update;
  mwss_pkg::mwss_shape_ctrl_t move_ctrl, turn_ctrl;

  assign move_ctrl = '{ramp_mode:       raw_static_q,
                       boost_en:        1'b1,
                       boost_gap:       boost_gap_q,
                       boost_min_speed: boost_min_speed_q};
  assign turn_ctrl = '{ramp_mode:       raw_static_q,
                       boost_en:        1'b0,
                       boost_gap:       boost_gap_q,
                       boost_min_speed: boost_min_speed_q};

  mwss_cmd_shaper u_side_shaper (
    .raw_i  (raw_side_q),
    .cmd_i  (side_cmd_q),
    .ctrl_i (move_ctrl),
    .cmd_o  (side_cmd_d)
  );

  mwss_cmd_shaper u_fwd_shaper (
    .raw_i  (raw_fwd_q),
    .cmd_i  (fwd_cmd_q),
    .ctrl_i (move_ctrl),
    .cmd_o  (fwd_cmd_d)
  );

  mwss_cmd_shaper u_turn_shaper (
    .raw_i  (raw_turn_q),
    .cmd_i  (turn_cmd_q),
    .ctrl_i (turn_ctrl),
    .cmd_o  (turn_cmd_d)
  );

  assign cmd_update = cmd_en && raw_valid_q && !raw_off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_cmd_q <= 20'sd0;
      fwd_cmd_q  <= 20'sd0;
      turn_cmd_q <= 20'sd0;
    end else if (cmd_update) begin
      side_cmd_q <= side_cmd_d;
      fwd_cmd_q  <= fwd_cmd_d;
      turn_cmd_q <= turn_cmd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_en && raw_valid_q) begin
      cmd_off_q <= raw_off_q;
    end
  end

  // Mixing stage.
  logic signed [21:0]  s_ext, f_ext, t_ext;
  mwss_pkg::mwss_out_t out_d, out_q;

  assign s_ext = 22'(side_cmd_q);
  assign f_ext = 22'(fwd_cmd_q);
  assign t_ext = 22'(turn_cmd_q);

  always_comb begin
    if (cmd_off_q) begin
      out_d = '{wheel_a: 16'sd0, wheel_b: 16'sd0, wheel_c: 16'sd0, wheel_d: 16'sd0,
                power_off: 1'b1};
    end else begin
      out_d.wheel_a   = sat_wheel(-(s_ext + f_ext + t_ext), wheel_limit_q);
      out_d.wheel_b   = sat_wheel(s_ext - f_ext - t_ext, wheel_limit_q);
      out_d.wheel_c   = sat_wheel(-(s_ext - f_ext + t_ext), wheel_limit_q);
      out_d.wheel_d   = sat_wheel(s_ext + f_ext - t_ext, wheel_limit_q);
      out_d.power_off = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && cmd_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[rtl/mwss_checker.sv]
// ----------------------------------------------------------------------------
// Mecanum wheel setpoint shaper checker
// Port-level assertions on flow control and result content.
// ----------------------------------------------------------------------------
`default_nettype none

module mwss_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input mwss_pkg::mwss_out_t out_data_o,
  input logic                pready
);

  // With no result waiting, every pipeline stage can move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while the output is empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.power_off) |->
      (out_data_o.wheel_a == 16'sd0) && (out_data_o.wheel_b == 16'sd0) &&
      (out_data_o.wheel_c == 16'sd0) && (out_data_o.wheel_d == 16'sd0))
    else $error("power-off result with nonzero wheel setpoint");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed or dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i || out_valid_o) |-> pready)
    else $error("configuration port not ready");

endmodule

bind mecanum_wheel_setpoint_shaper_unit mwss_checker u_mwss_checker (.*);

`default_nettype wire
